### rtl/core/mbesc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbesc_pkg;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int CNT_W   = 9;
  localparam int LIMIT_W = 8;
  localparam int FRAC    = 24;
  localparam int Z_W     = 32;
  localparam int PROD_W  = 2 * Z_W;
  localparam int QUO_W   = 10;
  localparam int DEPTH   = 1024;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd20;
  localparam logic [Z_W-1:0]     C_RE_OFS    = 32'(3) << (FRAC - 1);
  localparam logic [Z_W-1:0]     C_IM_OFS    = 32'(1) << (FRAC - 1);
  localparam logic [PROD_W-1:0]  FOUR_Q48    = 64'(4) << (2 * FRAC);

  typedef struct packed {
    logic [COL_W-1:0] pixel_col;
    logic [ROW_W-1:0] pixel_row;
  } in_req_t;

  typedef struct packed {
    logic             is_inside;
    logic [CNT_W-1:0] iter_count;
    logic [ROW_W-1:0] column_top_row;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_MUL,
    ST_UPD,
    ST_WRITE
  } state_t;

endpackage

`default_nettype wire

### rtl/core/mandelbrot_escape_with_column_top_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Mandelbrot escape-time classifier with a per-column top-row store. Each request
// (pixel_col, pixel_row) maps to c in Q.24 and iterates z = z*z + c; the result gives
// inside/outside, the step count and the column's recorded top row. One request is
// worked at a time: after the accepting edge, ST_DIV does the reciprocal multiplication for
// the remainder of the pixel mapping, then ST_SETUP, then each escape test takes ST_MUL (the
// shared set of three 32x32 multipliers) and ST_UPD (the add, compare and update), then
// ST_WRITE updates the store and loads the result register. With n steps there are
// n + 1 escape tests. The next request is accepted while a result still waits on
// out_ready, in the cycle after the result register loads; a finished request holds in
// the store update cycle while the result register is still full. After reset the
// column store (1024 x 10) is cleared in one pass over all 1024 entries during which
// in_ready is low; cfg writes are taken at any time.
module mandelbrot_escape_with_column_top_unit #(
  parameter int IMG_WIDTH  = 1024,
  parameter int IMG_HEIGHT = 1024
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire mbesc_pkg::in_req_t            in_req,
  output logic                               out_valid,
  input  wire                                out_ready,
  output mbesc_pkg::out_req_t                out_req,
  input  wire                                cfg_we,
  input  wire [mbesc_pkg::LIMIT_W-1:0]       cfg_wdata
);

  localparam int Q0_RE = (1 << mbesc_pkg::FRAC) / IMG_WIDTH;
  localparam int R0_RE = (1 << mbesc_pkg::FRAC) % IMG_WIDTH;
  localparam int Q0_IM = (1 << mbesc_pkg::FRAC) / IMG_HEIGHT;
  localparam int R0_IM = (1 << mbesc_pkg::FRAC) % IMG_HEIGHT;
  localparam int K_RE = mbesc_pkg::COL_W + 2 * $clog2(IMG_WIDTH);
  localparam int K_IM = mbesc_pkg::ROW_W + 2 * $clog2(IMG_HEIGHT);
  localparam longint M_RE = ((longint'(1) << K_RE) + IMG_WIDTH - 1) / IMG_WIDTH;
  localparam longint M_IM = ((longint'(1) << K_IM) + IMG_HEIGHT - 1) / IMG_HEIGHT;
  localparam int REM_RE_W = mbesc_pkg::COL_W + $clog2(IMG_WIDTH);
  localparam int REM_IM_W = mbesc_pkg::ROW_W + $clog2(IMG_HEIGHT);
  localparam int PRD_RE_W = REM_RE_W + K_RE - $clog2(IMG_WIDTH) + 1;
  localparam int PRD_IM_W = REM_IM_W + K_IM - $clog2(IMG_HEIGHT) + 1;
  localparam int ADDR_W = $clog2(mbesc_pkg::DEPTH);
  localparam int ZW = mbesc_pkg::Z_W;
  localparam int PW = mbesc_pkg::PROD_W;
  localparam int FR = mbesc_pkg::FRAC;

  mbesc_pkg::state_t state_r, state_nxt;

  logic [mbesc_pkg::LIMIT_W-1:0] limit_r;
  logic [ADDR_W-1:0]             clr_cnt_r;

  logic [mbesc_pkg::COL_W-1:0] col_r;
  logic [mbesc_pkg::ROW_W-1:0] row_r;
  logic [REM_RE_W-1:0]         rem_re_r;
  logic [REM_IM_W-1:0]         rem_im_r;
  logic [mbesc_pkg::QUO_W-1:0] qre_r, qim_r;
  logic [PRD_RE_W-1:0]         qre_prod;
  logic [PRD_IM_W-1:0]         qim_prod;

  logic signed [ZW-1:0] c_re_r, c_im_r, zr_r, zi_r;
  logic signed [PW-1:0] sr_r, si_r, pr_r;
  logic [mbesc_pkg::CNT_W-1:0] cnt_r;
  logic                        inside_r;

  logic [mbesc_pkg::ROW_W-1:0] store_mem [mbesc_pkg::DEPTH];
  logic [mbesc_pkg::ROW_W-1:0] rd_r;

  logic                        out_valid_r;
  mbesc_pkg::out_req_t         out_r;

  logic                        in_fire, out_load, mem_we, keep_going, top_hit;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [mbesc_pkg::ROW_W-1:0] mem_wdata;
  logic [PW-1:0]               mag2;
  logic signed [PW-1:0]        diff;

  assign mag2       = $unsigned(sr_r) + $unsigned(si_r);
  assign diff       = sr_r - si_r;
  assign keep_going = (mag2 < mbesc_pkg::FOUR_Q48) &&
                      (cnt_r <= {1'b0, limit_r});
  assign top_hit    = inside_r && (rd_r == '0);
  assign in_fire    = in_valid && in_ready;
  assign qre_prod   = PRD_RE_W'(rem_re_r) * PRD_RE_W'(M_RE);
  assign qim_prod   = PRD_IM_W'(rem_im_r) * PRD_IM_W'(M_IM);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mbesc_pkg::ST_CLEAR: if (&clr_cnt_r) state_nxt = mbesc_pkg::ST_IDLE;
      mbesc_pkg::ST_IDLE:  if (in_valid) state_nxt = mbesc_pkg::ST_DIV;
      mbesc_pkg::ST_DIV:   state_nxt = mbesc_pkg::ST_SETUP;
      mbesc_pkg::ST_SETUP: state_nxt = mbesc_pkg::ST_MUL;
      mbesc_pkg::ST_MUL:   state_nxt = mbesc_pkg::ST_UPD;
      mbesc_pkg::ST_UPD:   state_nxt = keep_going ? mbesc_pkg::ST_MUL : mbesc_pkg::ST_WRITE;
      mbesc_pkg::ST_WRITE: if (!out_valid_r || out_ready) state_nxt = mbesc_pkg::ST_IDLE;
      default:  state_nxt = mbesc_pkg::ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_r;
    mem_wdata = '0;
    unique case (state_r)
      mbesc_pkg::ST_CLEAR: mem_we = 1'b1;
      mbesc_pkg::ST_IDLE:  in_ready = 1'b1;
      mbesc_pkg::ST_WRITE: begin
        out_load  = !out_valid_r || out_ready;
        mem_we    = out_load && top_hit;
        mem_waddr = col_r;
        mem_wdata = row_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbesc_pkg::ST_CLEAR;
      limit_r     <= mbesc_pkg::LIMIT_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
      if (state_r == mbesc_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Column store: one write port, one registered read at the current column.
  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_waddr] <= mem_wdata;
    rd_r <= store_mem[col_r];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      mbesc_pkg::ST_IDLE: begin
        if (in_fire) begin
          col_r    <= in_req.pixel_col;
          row_r    <= in_req.pixel_row;
          rem_re_r <= REM_RE_W'(REM_RE_W'(in_req.pixel_col) * REM_RE_W'(R0_RE));
          rem_im_r <= REM_IM_W'(REM_IM_W'(in_req.pixel_row) * REM_IM_W'(R0_IM));
        end
      end
      mbesc_pkg::ST_DIV: begin
        // Reciprocal multiply gives the exact floor of remainder / size for any pixel.
        qre_r <= qre_prod[K_RE +: mbesc_pkg::QUO_W];
        qim_r <= qim_prod[K_IM +: mbesc_pkg::QUO_W];
      end
      mbesc_pkg::ST_SETUP: begin
        c_re_r <= $signed(ZW'(col_r) * ZW'(Q0_RE) + ZW'(qre_r) - mbesc_pkg::C_RE_OFS);
        c_im_r <= $signed(ZW'(row_r) * ZW'(Q0_IM) + ZW'(qim_r) - mbesc_pkg::C_IM_OFS);
        zr_r   <= '0;
        zi_r   <= '0;
        cnt_r  <= '0;
      end
      mbesc_pkg::ST_MUL: begin
        sr_r <= zr_r * zr_r;
        si_r <= zi_r * zi_r;
        pr_r <= zr_r * zi_r;
      end
      mbesc_pkg::ST_UPD: begin
        if (keep_going) begin
          // Floor shifts of exact Q.48 values; the doubling folds into the select.
          zr_r  <= $signed(diff[FR+ZW-1:FR]) + c_re_r;
          zi_r  <= $signed(pr_r[FR+ZW-2:FR-1]) + c_im_r;
          cnt_r <= cnt_r + 1'b1;
        end else begin
          inside_r <= (cnt_r >= {1'b0, limit_r});
        end
      end
      mbesc_pkg::ST_WRITE: begin
        if (out_load) begin
          out_r.is_inside      <= inside_r;
          out_r.iter_count     <= cnt_r;
          out_r.column_top_row <= top_hit ? row_r : rd_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_r;

endmodule

`default_nettype wire
